[rtl/textured_span_pixel_writer_core_macros.svh]
// assertion helpers for textured_span_pixel_writer_core
`ifndef TEXTURED_SPAN_PIXEL_WRITER_CORE_MACROS_SVH
`define TEXTURED_SPAN_PIXEL_WRITER_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define TSPW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define TSPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tspw_pkg.sv]
`timescale 1ns / 1ps

package tspw_pkg;

    // texture store size in bytes, a power of two
    localparam int TEXTURE_BYTES = 65536;
    localparam int TEX_AW        = $clog2(TEXTURE_BYTES);
    localparam int TEX_WORDS     = TEXTURE_BYTES / 2;
    localparam int TEX_WAW       = TEX_AW - 1;

    // frame buffer geometry
    localparam int ROW_PITCH     = 512;
    localparam int PAGE_OFFSET   = 'h40000;
    localparam int TEX_PAGE_UNIT = 256;
    localparam logic [15:0] HIGH_BYTE_MASK = 16'hff00;

    // request commands
    typedef enum logic [1:0] {
        CMD_TEX_WRITE  = 2'd0,
        CMD_SPAN_START = 2'd1,
        CMD_STEP       = 2'd2,
        CMD_UNUSED     = 2'd3
    } cmd_t;

    // span kinds
    typedef enum logic [1:0] {
        KIND_FLAT   = 2'd0,
        KIND_TEX    = 2'd1,
        KIND_TRANSP = 2'd2,
        KIND_MASK   = 2'd3
    } kind_t;

    // texture store write port
    typedef struct packed {
        logic               en;
        logic [TEX_WAW-1:0] word_index;
        logic [15:0]        data;
    } tex_wr_t;

    // texture store read port, byte address
    typedef struct packed {
        logic              en;
        logic [TEX_AW-1:0] byte_addr;
    } tex_rd_t;

endpackage

[rtl/tspw_tex_store.sv]
`timescale 1ns / 1ps

module tspw_tex_store
(
    input  logic             clk,
    input  tspw_pkg::tex_wr_t wr,
    input  tspw_pkg::tex_rd_t rd,
    output logic [7:0]       texel
);

    logic [15:0] mem [tspw_pkg::TEX_WORDS];
    logic [15:0] rdata_reg;
    logic        sel_reg;

    // word-wide store, low byte at the even address
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.word_index] <= wr.data;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata_reg <= mem[rd.byte_addr[tspw_pkg::TEX_AW-1:1]];
            sel_reg   <= rd.byte_addr[0];
        end
    end

    // byte select
    assign texel = sel_reg ? rdata_reg[15:8] : rdata_reg[7:0];

endmodule

[rtl/textured_span_pixel_writer_core.sv]
`timescale 1ns / 1ps

// Span pixel writer: takes one request per clock while item_ready is high
// (texture word write, span start or pixel step) and returns one pixel
// result per step request. The texel read of the texture RAM is registered,
// and an output register holds the result until it is taken; a stalled
// output stops requests only once the texel stage is also full. Texture
// reads see every texture write accepted before the step. The user must
// write draw_page only while no step is in flight; it is not enforced.
module textured_span_pixel_writer_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               draw_page_we,
    input  logic               draw_page,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         command,
    input  logic [8:0]         scanline,
    input  logic [8:0]         start_x,
    input  logic [9:0]         stop_x,
    input  logic signed [31:0] u_start,
    input  logic signed [31:0] v_start,
    input  logic signed [31:0] u_delta,
    input  logic signed [31:0] v_delta,
    input  logic [15:0]        color_word,
    input  logic [2:0]         span_mode,
    input  logic [7:0]         texture_page,
    input  logic [14:0]        texture_word_address,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [18:0]        pixel_address,
    output logic [15:0]        pixel_data,
    output logic               write_enable,
    output logic               span_last
);

    `include "textured_span_pixel_writer_core_macros.svh"

    // span state
    logic                draw_page_reg;
    logic [9:0]          cur_x_reg, cur_x_next;
    logic [9:0]          end_x_reg, end_x_next;
    logic [8:0]          row_reg, row_next;
    logic [31:0]         u_acc_reg, u_acc_next;
    logic [31:0]         v_acc_reg, v_acc_next;
    logic [31:0]         u_step_reg, u_step_next;
    logic [31:0]         v_step_reg, v_step_next;
    logic [15:0]         color_reg, color_next;
    tspw_pkg::kind_t     kind_reg, kind_next;
    logic                dither_reg, dither_next;
    logic [15:0]         tex_base_reg, tex_base_next;

    // texel stage
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_done_reg;
    tspw_pkg::kind_t     s1_kind_reg;
    logic [15:0]         s1_color_reg;
    logic [18:0]         s1_addr_reg;
    logic                s1_last_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [18:0]         out_addr_reg;
    logic [15:0]         out_data_reg;
    logic                out_we_reg;
    logic                out_last_reg;

    logic                accept;
    logic                step_accept;
    logic                out_free;
    logic                s1_adv;
    logic                span_done;
    logic [10:0]         nx;
    logic [9:0]          step_x_next;
    logic [31:0]         tex_sum;
    logic [31:0]         pix_sum;
    logic [18:0]         pix_addr;
    logic [9:0]          first_x;
    logic                shift_first;
    logic [7:0]          texel;
    logic [18:0]         s1_out_addr;
    logic [15:0]         s1_out_data;
    logic                s1_out_we;
    logic                s1_out_last;
    tspw_pkg::tex_wr_t   tex_wr;
    tspw_pkg::tex_rd_t   tex_rd;

    // handshake
    assign out_free    = !out_valid_reg || result_ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign item_ready  = !s1_valid_reg || out_free;
    assign accept      = item_valid && item_ready;
    assign step_accept = accept && (tspw_pkg::cmd_t'(command) == tspw_pkg::CMD_STEP);

    // texel byte address from the stored accumulators, u high half signed
    assign tex_sum = 32'(tex_base_reg) + {16'd0, v_acc_reg[23:16], 8'd0}
                   + {{16{u_acc_reg[31]}}, u_acc_reg[31:16]};

    // frame buffer address of the current pixel
    assign pix_sum  = (draw_page_reg ? 32'(tspw_pkg::PAGE_OFFSET) : 32'd0)
                    + 32'(row_reg) * 32'(tspw_pkg::ROW_PITCH) + 32'(cur_x_reg);
    assign pix_addr = pix_sum[18:0];

    // x advance, saturating at the span end
    assign span_done   = cur_x_reg >= end_x_reg;
    assign nx          = {1'b0, cur_x_reg} + (dither_reg ? 11'd2 : 11'd1);
    assign step_x_next = (nx >= {1'b0, end_x_reg}) ? end_x_reg : nx[9:0];

    // dithered spans start on the matching parity
    assign shift_first = span_mode[2] && (scanline[0] ^ start_x[0]);
    assign first_x     = {1'b0, start_x} + (shift_first ? 10'd1 : 10'd0);

    // texture store ports
    always_comb
    begin
        tex_wr.en         = accept
                          && (tspw_pkg::cmd_t'(command) == tspw_pkg::CMD_TEX_WRITE);
        tex_wr.word_index = tspw_pkg::TEX_WAW'(texture_word_address);
        tex_wr.data       = color_word;
        tex_rd.en         = step_accept;
        tex_rd.byte_addr  = tex_sum[tspw_pkg::TEX_AW-1:0];
    end

    tspw_tex_store u_tex_store
    (
        .clk   (clk),
        .wr    (tex_wr),
        .rd    (tex_rd),
        .texel (texel)
    );

    // span state next values
    always_comb
    begin
        cur_x_next    = cur_x_reg;
        end_x_next    = end_x_reg;
        row_next      = row_reg;
        u_acc_next    = u_acc_reg;
        v_acc_next    = v_acc_reg;
        u_step_next   = u_step_reg;
        v_step_next   = v_step_reg;
        color_next    = color_reg;
        kind_next     = kind_reg;
        dither_next   = dither_reg;
        tex_base_next = tex_base_reg;
        if (accept)
        begin
            unique case (tspw_pkg::cmd_t'(command))
                tspw_pkg::CMD_SPAN_START:
                begin
                    row_next      = scanline;
                    end_x_next    = stop_x;
                    cur_x_next    = first_x;
                    u_acc_next    = $unsigned(u_start)
                                  + (shift_first ? $unsigned(u_delta) : 32'd0);
                    v_acc_next    = $unsigned(v_start)
                                  + (shift_first ? $unsigned(v_delta) : 32'd0);
                    u_step_next   = span_mode[2] ? {u_delta[30:0], 1'b0}
                                                 : $unsigned(u_delta);
                    v_step_next   = span_mode[2] ? {v_delta[30:0], 1'b0}
                                                 : $unsigned(v_delta);
                    color_next    = color_word;
                    kind_next     = tspw_pkg::kind_t'(span_mode[1:0]);
                    dither_next   = span_mode[2];
                    tex_base_next = 16'(32'(texture_page) * 32'(tspw_pkg::TEX_PAGE_UNIT));
                end
                tspw_pkg::CMD_STEP:
                begin
                    if (!span_done)
                    begin
                        cur_x_next = step_x_next;
                        u_acc_next = u_acc_reg + u_step_reg;
                        v_acc_next = v_acc_reg + v_step_reg;
                    end
                end
                tspw_pkg::CMD_TEX_WRITE,
                tspw_pkg::CMD_UNUSED:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // config and span state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_page_reg <= 1'b0;
            cur_x_reg     <= '0;
            end_x_reg     <= '0;
            row_reg       <= '0;
            u_acc_reg     <= '0;
            v_acc_reg     <= '0;
            u_step_reg    <= '0;
            v_step_reg    <= '0;
            color_reg     <= '0;
            kind_reg      <= tspw_pkg::KIND_FLAT;
            dither_reg    <= 1'b0;
            tex_base_reg  <= '0;
        end
        else
        begin
            if (draw_page_we)
            begin
                draw_page_reg <= draw_page;
            end
            cur_x_reg    <= cur_x_next;
            end_x_reg    <= end_x_next;
            row_reg      <= row_next;
            u_acc_reg    <= u_acc_next;
            v_acc_reg    <= v_acc_next;
            u_step_reg   <= u_step_next;
            v_step_reg   <= v_step_next;
            color_reg    <= color_next;
            kind_reg     <= kind_next;
            dither_reg   <= dither_next;
            tex_base_reg <= tex_base_next;
        end
    end

    // texel stage valid
    assign s1_valid_next = step_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // texel stage payload, loaded alongside the texture read
    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            s1_done_reg  <= span_done;
            s1_kind_reg  <= kind_reg;
            s1_color_reg <= color_reg;
            s1_addr_reg  <= pix_addr;
            s1_last_reg  <= step_x_next >= end_x_reg;
        end
    end

    // pixel value from kind and texel
    always_comb
    begin
        s1_out_addr = s1_addr_reg;
        s1_out_last = s1_last_reg;
        s1_out_data = s1_color_reg;
        s1_out_we   = 1'b1;
        unique case (s1_kind_reg)
            tspw_pkg::KIND_FLAT:
            begin
                s1_out_data = s1_color_reg;
            end
            tspw_pkg::KIND_TEX:
            begin
                s1_out_data = (s1_color_reg & tspw_pkg::HIGH_BYTE_MASK) | {8'd0, texel};
            end
            tspw_pkg::KIND_TRANSP:
            begin
                s1_out_data = (s1_color_reg & tspw_pkg::HIGH_BYTE_MASK) | {8'd0, texel};
                s1_out_we   = texel != 8'd0;
            end
            tspw_pkg::KIND_MASK:
            begin
                s1_out_we   = texel != 8'd0;
            end
            default:
            begin
            end
        endcase
        // step after the span end
        if (s1_done_reg)
        begin
            s1_out_addr = '0;
            s1_out_data = '0;
            s1_out_we   = 1'b0;
            s1_out_last = 1'b1;
        end
    end

    // output register
    assign out_valid_next = s1_adv ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_addr_reg <= s1_out_addr;
            out_data_reg <= s1_out_data;
            out_we_reg   <= s1_out_we;
            out_last_reg <= s1_out_last;
        end
    end

    assign result_valid  = out_valid_reg;
    assign pixel_address = out_addr_reg;
    assign pixel_data    = out_data_reg;
    assign write_enable  = out_we_reg;
    assign span_last     = out_last_reg;

    // checks
    `TSPW_ASSERT_NEXT(a_x_saturates, step_accept && !span_done,
        cur_x_reg <= end_x_reg, "x stepped past the span end")
    `TSPW_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !out_free,
        s1_valid_reg && $stable(s1_addr_reg), "texel stage lost a stalled pixel")
    `TSPW_ASSERT_NOW(a_ready_only_full, !item_ready,
        s1_valid_reg && out_valid_reg && !result_ready, "request refused with room left")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

    // one request as offered on the input channel
    typedef struct {
        tspw_pkg::cmd_t command;
        logic [8:0]     scanline;
        logic [8:0]     start_x;
        logic [9:0]     stop_x;
        logic [31:0]    u_start;
        logic [31:0]    v_start;
        logic [31:0]    u_delta;
        logic [31:0]    v_delta;
        logic [15:0]    color_word;
        logic [2:0]     span_mode;
        logic [7:0]     texture_page;
        logic [14:0]    texture_word_address;
    } raster_req_t;

    // one frame buffer write as seen on the output channel
    typedef struct {
        logic [18:0] addr;
        logic [15:0] data;
        logic        we;
        logic        last;
    } pixel_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               draw_page_we = 1'b0;
    logic               draw_page = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    logic [1:0]         command = '0;
    logic [8:0]         scanline = '0;
    logic [8:0]         start_x = '0;
    logic [9:0]         stop_x = '0;
    logic signed [31:0] u_start = '0;
    logic signed [31:0] v_start = '0;
    logic signed [31:0] u_delta = '0;
    logic signed [31:0] v_delta = '0;
    logic [15:0]        color_word = '0;
    logic [2:0]         span_mode = '0;
    logic [7:0]         texture_page = '0;
    logic [14:0]        texture_word_address = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [18:0]        pixel_address;
    logic [15:0]        pixel_data;
    logic               write_enable;
    logic               span_last;

    textured_span_pixel_writer_core dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .draw_page_we         (draw_page_we),
        .draw_page            (draw_page),
        .item_valid           (item_valid),
        .item_ready           (item_ready),
        .command              (command),
        .scanline             (scanline),
        .start_x              (start_x),
        .stop_x               (stop_x),
        .u_start              (u_start),
        .v_start              (v_start),
        .u_delta              (u_delta),
        .v_delta              (v_delta),
        .color_word           (color_word),
        .span_mode            (span_mode),
        .texture_page         (texture_page),
        .texture_word_address (texture_word_address),
        .result_valid         (result_valid),
        .result_ready         (result_ready),
        .pixel_address        (pixel_address),
        .pixel_data           (pixel_data),
        .write_enable         (write_enable),
        .span_last            (span_last)
    );

    always #5 clk = ~clk;

    // queues between stimulus, driver, predictor and checker
    raster_req_t request_q[$];
    pixel_t      pixel_q[$];
    raster_req_t offered;
    logic        sending = 1'b0;
    int          mismatch_count = 0;

    // receiver long holds asked by the stimulus and served by the receiver
    int          hold_asked = 0;
    int          hold_given = 0;

    // predicted block state
    logic [7:0]  texture_copy [0:tspw_pkg::TEXTURE_BYTES-1];
    bit          texture_loaded [0:tspw_pkg::TEXTURE_BYTES-1];
    logic [9:0]  span_x = '0;
    logic [9:0]  span_end = '0;
    logic [8:0]  span_row = '0;
    logic [31:0] u_acc = '0;
    logic [31:0] v_acc = '0;
    logic [31:0] u_stp = '0;
    logic [31:0] v_stp = '0;
    logic [15:0] span_color = '0;
    logic [2:0]  span_kind = '0;
    logic [15:0] tex_base = '0;
    logic        page_r = 1'b0;
    logic [15:0] fetch_addr = '0;

    // texel byte address for the current pixel, signed u wraps in the store
    function automatic logic [15:0] texel_byte_addr();
        return tex_base + {v_acc[23:16], 8'h00} + u_acc[31:16];
    endfunction

    // zero texels are common so transparent and mask spans skip often
    function automatic logic [7:0] texel_value();
        return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    // predictor: update state for one accepted request, queue any pixel
    function automatic void rasterize_request(input raster_req_t rq);
        pixel_t      px;
        logic [9:0]  first_x;
        logic [10:0] next_x;
        logic [15:0] texel_addr;
        logic [7:0]  texel;
        int          addr_sum;
        case (rq.command)
            tspw_pkg::CMD_TEX_WRITE:
            begin
                texture_copy[{rq.texture_word_address, 1'b0}]   = rq.color_word[7:0];
                texture_copy[{rq.texture_word_address, 1'b1}]   = rq.color_word[15:8];
                texture_loaded[{rq.texture_word_address, 1'b0}] = 1'b1;
                texture_loaded[{rq.texture_word_address, 1'b1}] = 1'b1;
            end
            tspw_pkg::CMD_SPAN_START:
            begin
                span_row   = rq.scanline;
                span_end   = rq.stop_x;
                u_acc      = rq.u_start;
                v_acc      = rq.v_start;
                u_stp      = rq.u_delta;
                v_stp      = rq.v_delta;
                span_color = rq.color_word;
                span_kind  = rq.span_mode;
                tex_base   = {rq.texture_page, 8'h00};
                first_x    = {1'b0, rq.start_x};
                // dither: align first pixel on row/x parity, then double step
                if (rq.span_mode[2])
                begin
                    if (rq.scanline[0] ^ rq.start_x[0])
                    begin
                        first_x = first_x + 10'd1;
                        u_acc   = u_acc + u_stp;
                        v_acc   = v_acc + v_stp;
                    end
                    u_stp = u_stp << 1;
                    v_stp = v_stp << 1;
                end
                span_x = first_x;
            end
            tspw_pkg::CMD_STEP:
            begin
                if (span_x >= span_end)
                begin
                    px.addr = '0;
                    px.data = '0;
                    px.we   = 1'b0;
                    px.last = 1'b1;
                end
                else
                begin
                    texel_addr = texel_byte_addr();
                    texel      = texture_copy[texel_addr];
                    px.we      = 1'b1;
                    case (tspw_pkg::kind_t'(span_kind[1:0]))
                        tspw_pkg::KIND_FLAT:
                            px.data = span_color;
                        tspw_pkg::KIND_TEX:
                            px.data = {span_color[15:8], texel};
                        tspw_pkg::KIND_TRANSP:
                        begin
                            px.data = {span_color[15:8], texel};
                            px.we   = texel != 8'h00;
                        end
                        tspw_pkg::KIND_MASK:
                        begin
                            px.data = span_color;
                            px.we   = texel != 8'h00;
                        end
                    endcase
                    addr_sum = int'(page_r) * tspw_pkg::PAGE_OFFSET
                             + int'(span_row) * tspw_pkg::ROW_PITCH + int'(span_x);
                    px.addr  = addr_sum[18:0];
                    next_x   = {1'b0, span_x} + (span_kind[2] ? 11'd2 : 11'd1);
                    span_x   = (next_x >= {1'b0, span_end}) ? span_end : next_x[9:0];
                    u_acc    = u_acc + u_stp;
                    v_acc    = v_acc + v_stp;
                    px.last  = span_x >= span_end;
                end
                pixel_q.push_back(px);
            end
            default:
                ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        // keep the log short when everything goes wrong
        if (mismatch_count <= 100)
            $display("tb: %s mismatch: got %0h, want %0h", what, got, want);
    endtask

    // driver: bursts of requests with random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            sending = 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (sending && item_ready)
            begin
                rasterize_request(offered);
                sending = 1'b0;
            end
            if (!sending)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    offered = request_q.pop_front();
                    // a textured step first loads the texel it is about to read
                    fetch_addr = texel_byte_addr();
                    if (offered.command == tspw_pkg::CMD_STEP && span_x < span_end
                        && tspw_pkg::kind_t'(span_kind[1:0]) != tspw_pkg::KIND_FLAT
                        && !texture_loaded[fetch_addr])
                    begin
                        request_q.push_front(offered);
                        offered.command              = tspw_pkg::CMD_TEX_WRITE;
                        offered.texture_word_address = fetch_addr[15:1];
                        offered.color_word           = {texel_value(), texel_value()};
                    end
                    command              <= offered.command;
                    scanline             <= offered.scanline;
                    start_x              <= offered.start_x;
                    stop_x               <= offered.stop_x;
                    u_start              <= offered.u_start;
                    v_start              <= offered.v_start;
                    u_delta              <= offered.u_delta;
                    v_delta              <= offered.v_delta;
                    color_word           <= offered.color_word;
                    span_mode            <= offered.span_mode;
                    texture_page         <= offered.texture_page;
                    texture_word_address <= offered.texture_word_address;
                    item_valid           <= 1'b1;
                    sending = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 4);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver: ready pattern in stretches, plus long holds on request
    int hold_left = 0;
    int ready_mode = 0;
    int mode_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (hold_given != hold_asked)
        begin
            hold_given = hold_asked;
            hold_left = 300;
            result_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (ready_mode)
                0: result_ready <= 1'b1;
                1: result_ready <= $urandom_range(0, 1);
                default: result_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // checker: compare each taken pixel with the oldest prediction
    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pixel_q.size() == 0)
                report_mismatch("unexpected pixel", 32'(pixel_address), 32'd0);
            else
            begin
                want = pixel_q.pop_front();
                if (pixel_address !== want.addr)
                    report_mismatch("pixel_address", 32'(pixel_address), 32'(want.addr));
                if (pixel_data !== want.data)
                    report_mismatch("pixel_data", 32'(pixel_data), 32'(want.data));
                if (write_enable !== want.we)
                    report_mismatch("write_enable", 32'(write_enable), 32'(want.we));
                if (span_last !== want.last)
                    report_mismatch("span_last", 32'(span_last), 32'(want.last));
            end
        end
    end

    // request builders
    function automatic raster_req_t noise_req(input tspw_pkg::cmd_t cmd);
        raster_req_t rq;
        rq.command              = cmd;
        rq.scanline             = 9'($urandom);
        rq.start_x              = 9'($urandom);
        rq.stop_x               = 10'($urandom_range(0, 512));
        rq.u_start              = $urandom;
        rq.v_start              = $urandom;
        rq.u_delta              = $urandom;
        rq.v_delta              = $urandom;
        rq.color_word           = 16'($urandom);
        rq.span_mode            = 3'($urandom);
        rq.texture_page         = 8'($urandom);
        rq.texture_word_address = 15'($urandom);
        return rq;
    endfunction

    function automatic raster_req_t tex_write_req(input logic [14:0] waddr,
                                                  input logic [15:0] data);
        raster_req_t rq;
        rq = noise_req(tspw_pkg::CMD_TEX_WRITE);
        rq.texture_word_address = waddr;
        rq.color_word = data;
        return rq;
    endfunction

    function automatic raster_req_t span_req(input logic [8:0] row, input logic [8:0] sx,
                                             input logic [9:0] ex, input logic [31:0] u,
                                             input logic [31:0] v, input logic [31:0] du,
                                             input logic [31:0] dv, input logic [15:0] color,
                                             input logic [2:0] mode, input logic [7:0] tpage);
        raster_req_t rq;
        rq = noise_req(tspw_pkg::CMD_SPAN_START);
        rq.scanline     = row;
        rq.start_x      = sx;
        rq.stop_x       = ex;
        rq.u_start      = u;
        rq.v_start      = v;
        rq.u_delta      = du;
        rq.v_delta      = dv;
        rq.color_word   = color;
        rq.span_mode    = mode;
        rq.texture_page = tpage;
        return rq;
    endfunction

    function automatic logic [31:0] rand_coord();
        return ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 32'h00ff_ffff));
    endfunction

    function automatic logic [31:0] rand_slope();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
    endfunction

    task automatic queue_steps(input int n);
        repeat (n)
            request_q.push_back(noise_req(tspw_pkg::CMD_STEP));
    endtask

    // random work: mostly whole spans, some noise
    task automatic queue_random_work(input int count);
        raster_req_t rq;
        int pushed;
        int pick;
        int span_len;
        int xstep;
        int steps;
        int sx;
        int ex;
        pushed = 0;
        while (pushed < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                pick = $urandom_range(0, 99);
                sx = (pick < 10) ? 0 : (pick < 20) ? 511 : $urandom_range(0, 511);
                pick = $urandom_range(0, 99);
                if (pick < 95)
                    ex = sx + $urandom_range(0, 20);
                else if (pick < 99)
                    ex = $urandom_range(0, 512);
                else
                begin
                    sx = $urandom_range(448, 511);
                    ex = 512;
                end
                if (ex > 512)
                    ex = 512;
                rq = span_req(9'($urandom), 9'(sx), 10'(ex), rand_coord(), rand_coord(),
                              rand_slope(), rand_slope(), 16'($urandom), 3'($urandom),
                              8'($urandom));
                request_q.push_back(rq);
                pushed++;
                span_len = (ex > sx) ? ex - sx : 0;
                xstep = rq.span_mode[2] ? 2 : 1;
                steps = (span_len + xstep - 1) / xstep + $urandom_range(0, 1);
                // sometimes cut the span short with a new one
                if ($urandom_range(0, 9) == 0)
                    steps = $urandom_range(0, steps);
                queue_steps(steps);
                pushed += steps;
            end
            else if (pick < 84)
            begin
                request_q.push_back(tex_write_req(15'($urandom),
                                                  {texel_value(), texel_value()}));
                pushed++;
            end
            else if (pick < 94)
            begin
                queue_steps(1);
                pushed++;
            end
            else
                request_q.push_back(noise_req(tspw_pkg::CMD_UNUSED));
        end
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || sending || pixel_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_draw_page(input logic value);
        // let the texel pipeline settle after the last write or span start
        repeat (8) @(posedge clk);
        draw_page_we <= 1'b1;
        draw_page    <= value;
        @(posedge clk);
        draw_page_we <= 1'b0;
        page_r = value;
    endtask

    // stimulus
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_draw_page(1'b0);

        // step straight after reset finds an empty span
        queue_steps(1);
        request_q.push_back(noise_req(tspw_pkg::CMD_UNUSED));

        // known texels at both ends of the store
        request_q.push_back(tex_write_req(15'd0, 16'h5a00));
        request_q.push_back(tex_write_req(15'h7fff, 16'hc300));

        // flat fill at the last row up to the right edge
        request_q.push_back(span_req(9'd511, 9'd508, 10'd512, '0, '0, '0, '0,
                                     16'hffff, 3'd0, 8'hff));
        queue_steps(5);

        // textured, u starts at -1 and wraps to the top of the store
        request_q.push_back(span_req(9'd0, 9'd0, 10'd2, 32'hffff_0000, '0,
                                     32'h0001_0000, '0, 16'h1234, 3'd1, 8'h00));
        queue_steps(2);

        // transparent: first texel zero and skipped
        request_q.push_back(span_req(9'd7, 9'd10, 10'd12, '0, '0, 32'h0001_0000, '0,
                                     16'habcd, 3'd2, 8'h00));
        queue_steps(2);

        // dithered mask with odd row/x parity, first pixel moved right
        request_q.push_back(span_req(9'd2, 9'd3, 10'd7, '0, '0, 32'h0001_0000, '0,
                                     16'h8001, 3'd7, 8'h00));
        queue_steps(3);

        // reversed span gives a done result at once
        request_q.push_back(span_req(9'd100, 9'd100, 10'd50, '0, '0, '0, '0,
                                     16'h0000, 3'd1, 8'h00));
        queue_steps(1);

        // extreme accumulators with dithered texturing, even parity
        request_q.push_back(span_req(9'd510, 9'd0, 10'd3, 32'h7fff_ffff, 32'h8000_0000,
                                     32'h8000_0000, 32'h7fff_ffff, 16'h7f7f, 3'd5, 8'h80));
        queue_steps(3);
        wait_drained();

        // random phases with page changes and pauses in between
        for (int chunk = 0; chunk < 5; chunk++)
        begin
            case (chunk)
                1: set_draw_page(1'b1);
                2: hold_asked++;
                3: set_draw_page(1'b0);
                4: set_draw_page(1'b1);
                default: ;
            endcase
            queue_random_work(60);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #10ms;
        $display("tb: errors");
        $finish;
    end

endmodule
